// ===== sv/wat_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the windowed average and trend block.
// No dependencies; imported by wat_queue, wat_front, wat_back and the top module.
package wat_pkg;

   localparam int SAMPLE_W    = 40;
   localparam int TREND_W     = 41;
   localparam int WINDOW_DEF  = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_RECENT,
      DIV_OLDER
   } div_sel_type;

endpackage

// ===== sv/wat_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wat_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO between the front and back halves of the block.
// Depends on wat_pkg for the default depth.
module wat_queue import wat_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = store[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ===== sv/wat_div.sv =====
`timescale 1ns / 1ps
// Bit-serial signed-by-unsigned divider, truncating toward zero.
// One quotient bit per cycle. Depends on nothing.
module wat_div #(
   parameter int DVD_W = 16,
   parameter int DVS_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [DVD_W-1:0]    q_ff, q_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [DVS_W:0]      trial;
   logic                fits;

   assign trial = {rem_ff, q_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         neg_in  = dividend[DVD_W-1];
         q_in    = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // restoring step: remainder stays below the divisor
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         q_in    = {q_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;

endmodule

// ===== sv/wat_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts sample beats, assigns the ring slot and fill count,
// and pushes the tagged item into the queue. Depends on wat_pkg.
module wat_front import wat_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        q_full,
   output logic                        push,
   output logic [SAMPLE_W+$clog2(WINDOW)+$clog2(WINDOW+1)-1:0] push_data
);

   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] fill_next;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // fill count saturates at the window length
   assign fill_next = (fill_ff == CNT_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;
   assign push_data = {req_sample, wp_ff, fill_next};

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (push) begin
         wp_in   = (wp_ff == PTR_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/wat_back.sv =====
`timescale 1ns / 1ps
// Back end: stores the sample, walks the ring newest first summing both
// halves, runs up to three divisions on a shared divider and holds the result beat.
// Depends on wat_pkg, wat_ram and wat_div.
module wat_back import wat_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   output logic                       pop,
   input  logic [SAMPLE_W+$clog2(WINDOW)+$clog2(WINDOW+1)-1:0] q_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_window_mean,
   output logic signed [TREND_W-1:0]  rsp_trend
);

   localparam int PTR_W   = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = SAMPLE_W + CNT_W;
   localparam int ENTRY_W = SAMPLE_W + PTR_W + CNT_W;

   back_state_type state_ff, state_in;
   div_sel_type    sel_ff, sel_in;

   logic [SAMPLE_W-1:0]       sample_ff, sample_in;
   logic [PTR_W-1:0]          addr_ff, addr_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          half_ff, half_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic [CNT_W-1:0]          acc_ff, acc_in;
   logic                      rvalid_ff, rvalid_in;
   logic signed [SUM_W-1:0]   recent_ff, recent_in;
   logic signed [SUM_W-1:0]   older_ff, older_in;
   logic signed [SAMPLE_W-1:0] qm_ff, qm_in;
   logic signed [SAMPLE_W-1:0] qr_ff, qr_in;
   logic signed [SAMPLE_W-1:0] qo_ff, qo_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_mean_ff, out_mean_in;
   logic signed [TREND_W-1:0] out_trend_ff, out_trend_in;

   logic                      ram_we;
   logic                      ram_re;
   logic [SAMPLE_W-1:0]       ram_rdata;
   logic signed [SUM_W-1:0]   rd_ext;
   logic                      div_start;
   logic signed [SUM_W-1:0]   div_dividend;
   logic [CNT_W-1:0]          div_divisor;
   logic                      div_done;
   logic signed [SUM_W-1:0]   div_quot;
   logic signed [TREND_W-1:0] trend_calc;

   wat_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (sample_ff),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   wat_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rd_ext = {{CNT_W{ram_rdata[SAMPLE_W-1]}}, ram_rdata};

   always_comb begin
      case (sel_ff)
         DIV_MEAN: begin
            div_dividend = recent_ff + older_ff;
            div_divisor  = n_ff;
         end
         DIV_RECENT: begin
            div_dividend = recent_ff;
            div_divisor  = half_ff;
         end
         DIV_OLDER: begin
            div_dividend = older_ff;
            div_divisor  = n_ff - half_ff;
         end
         default: begin
            div_dividend = recent_ff + older_ff;
            div_divisor  = n_ff;
         end
      endcase
   end

   assign trend_calc = (n_ff < CNT_W'(2)) ? '0 :
                       TREND_W'(qr_ff) - TREND_W'(qo_ff);

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      sample_in    = sample_ff;
      addr_in      = addr_ff;
      n_in         = n_ff;
      half_in      = half_ff;
      issue_in     = issue_ff;
      acc_in       = acc_ff;
      rvalid_in    = 1'b0;
      recent_in    = recent_ff;
      older_in     = older_ff;
      qm_in        = qm_ff;
      qr_in        = qr_ff;
      qo_in        = qo_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_mean_in  = out_mean_ff;
      out_trend_in = out_trend_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               sample_in = q_data[ENTRY_W-1 -: SAMPLE_W];
               addr_in   = q_data[CNT_W +: PTR_W];
               n_in      = q_data[CNT_W-1:0];
               half_in   = q_data[CNT_W-1:0] >> 1;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            issue_in  = '0;
            acc_in    = '0;
            recent_in = '0;
            older_in  = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // reads run ahead of the accumulation, which takes the registered read data
            if (issue_ff < n_ff) begin
               ram_re    = 1'b1;
               rvalid_in = 1'b1;
               issue_in  = issue_ff + 1'b1;
               addr_in   = (addr_ff == '0) ? PTR_W'(WINDOW - 1) : addr_ff - 1'b1;
            end
            if (rvalid_ff) begin
               if (acc_ff < half_ff) begin
                  recent_in = recent_ff + rd_ext;
               end else begin
                  older_in = older_ff + rd_ext;
               end
               acc_in = acc_ff + 1'b1;
               if (acc_ff == n_ff - 1'b1) begin
                  sel_in   = DIV_MEAN;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (sel_ff)
                  DIV_MEAN: begin
                     qm_in = div_quot[SAMPLE_W-1:0];
                     if (n_ff < CNT_W'(2)) begin
                        state_in = ST_DONE;
                     end else begin
                        sel_in   = DIV_RECENT;
                        state_in = ST_DIV_START;
                     end
                  end
                  DIV_RECENT: begin
                     qr_in    = div_quot[SAMPLE_W-1:0];
                     sel_in   = DIV_OLDER;
                     state_in = ST_DIV_START;
                  end
                  DIV_OLDER: begin
                     qo_in    = div_quot[SAMPLE_W-1:0];
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_mean_in  = qm_ff;
               out_trend_in = trend_calc;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= DIV_MEAN;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      addr_ff      <= addr_in;
      n_ff         <= n_in;
      half_ff      <= half_in;
      issue_ff     <= issue_in;
      acc_ff       <= acc_in;
      recent_ff    <= recent_in;
      older_ff     <= older_in;
      qm_ff        <= qm_in;
      qr_ff        <= qr_in;
      qo_ff        <= qo_in;
      out_mean_ff  <= out_mean_in;
      out_trend_ff <= out_trend_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_window_mean = out_mean_ff;
   assign rsp_trend       = out_trend_ff;

endmodule

// ===== sv/windowed_average_and_trend.sv =====
`timescale 1ns / 1ps
// Time per sample grows with n, the fill count, and with SUM_W = 40 +
// clog2(WINDOW + 1); with one sample stored only the mean division runs.
// The back end takes a new sample only once it has finished the last: the ring
// walk and the up to three one-bit-per-cycle divisions on the shared divider
// set the pace. A two-beat queue and the result register let input and output
// stall independently.
// Synchronous active-high reset clears pointer, fill count and all handshakes.
module windowed_average_and_trend import wat_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_window_mean,
   output logic signed [TREND_W-1:0]  rsp_trend
);

   localparam int ENTRY_W = SAMPLE_W + $clog2(WINDOW) + $clog2(WINDOW + 1);

   logic               q_full;
   logic               q_empty;
   logic               push;
   logic               pop;
   logic [ENTRY_W-1:0] push_data;
   logic [ENTRY_W-1:0] pop_data;

   wat_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   wat_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   wat_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .pop             (pop),
      .q_data          (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_mean (rsp_window_mean),
      .rsp_trend       (rsp_trend)
   );

endmodule
